// ===== hw/rtl/hexl_pkg.sv =====
package hexl_pkg;

  // result kinds as seen on the output channel
  typedef enum logic [2:0] {
    K_WRITE   = 3'd0,
    K_EMPTY   = 3'd1,
    K_IGNORED = 3'd2,
    K_EOF     = 3'd3,
    K_CSUM    = 3'd4,
    K_LEN     = 3'd5
  } kind_t;

  // parser line state
  typedef enum logic [1:0] {
    LM_START  = 2'd0,
    LM_RECORD = 2'd1,
    LM_SKIP   = 2'd2,
    LM_HALT   = 2'd3
  } line_mode_t;

  // emitter state
  typedef enum logic {
    BS_IDLE = 1'b0,
    BS_OUT  = 1'b1
  } back_state_t;

  // record data length and buffer index cover the largest supported record
  localparam int LEN_W = 6;
  localparam int IDX_W = 6;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;

  // header bytes before data, plus checksum byte
  localparam int HDR_BYTES = 4;
  localparam int REC_OVERHEAD = 5;

  // one closed record line, handed from parser to emitter
  typedef struct packed {
    kind_t              kind;
    logic [LEN_W-1:0]   len;
    logic [15:0]        addr;
    logic               bank;
  } cmd_t;

  // data byte write into the record buffer
  typedef struct packed {
    logic               en;
    logic               bank;
    logic [IDX_W-1:0]   idx;
    logic [7:0]         data;
  } buf_wr_t;

endpackage

// ===== hw/rtl/hexl_if.sv =====
// character stream into the loader
interface hexl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_input;

  modport source (output valid, output character, output end_of_input, input ready);
  modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

// results out of the loader
interface hexl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic        last;

  modport source (output valid, output kind, output write_address, output write_data,
                  output last, input ready);
  modport sink   (input valid, input kind, input write_address, input write_data,
                  input last, output ready);
endinterface

// ===== hw/rtl/hexl_front.sv =====
module hexl_front #(
  parameter int MAX_DATA_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  hexl_in_if.sink           in_chan,
  input  logic              queue_full,
  output logic              push_valid,
  output hexl_pkg::cmd_t    push_cmd,
  output hexl_pkg::buf_wr_t buf_wr
);

  localparam int BUF_LEN = MAX_DATA_BYTES + hexl_pkg::REC_OVERHEAD;
  localparam int BCW     = $clog2(BUF_LEN + 1);

  hexl_pkg::line_mode_t mode_r, mode_nxt;
  logic           phase_r, phase_nxt;
  logic [3:0]     hi_r, hi_nxt;
  logic [BCW-1:0] count_r, count_nxt;
  logic           ovf_r, ovf_nxt;
  logic [7:0]     sum_r, sum_nxt;
  logic [7:0]     len_r, len_nxt;
  logic [7:0]     addr_hi_r, addr_hi_nxt;
  logic [7:0]     addr_lo_r, addr_lo_nxt;
  logic [7:0]     type_r, type_nxt;
  logic           bank_r, bank_nxt;

  logic           accept;
  logic           is_cr;
  logic           is_lf;
  logic           eoi;
  logic [3:0]     nib;
  logic [7:0]     new_byte;
  hexl_pkg::kind_t outcome;
  logic           halting;

  // input decode
  assign in_chan.ready = !queue_full;
  assign accept   = in_chan.valid && in_chan.ready;
  assign eoi      = in_chan.end_of_input;
  assign is_cr    = (in_chan.character == hexl_pkg::CH_CR);
  assign is_lf    = (in_chan.character == hexl_pkg::CH_LF);
  assign nib      = (in_chan.character > hexl_pkg::CH_NINE) ?
                    (in_chan.character[3:0] - 4'd7) : in_chan.character[3:0];
  assign new_byte = {hi_r, nib};

  // line outcome: checksum first, then length, then record type
  always_comb begin
    if (sum_r != 8'd0) begin
      outcome = hexl_pkg::K_CSUM;
    end else if (ovf_r || (count_r < BCW'(hexl_pkg::REC_OVERHEAD)) ||
                 (({1'b0, len_r} + 9'(hexl_pkg::REC_OVERHEAD)) != 9'(count_r))) begin
      outcome = hexl_pkg::K_LEN;
    end else if (type_r == hexl_pkg::REC_DATA) begin
      outcome = (len_r == 8'd0) ? hexl_pkg::K_EMPTY : hexl_pkg::K_WRITE;
    end else if (type_r == hexl_pkg::REC_EOF) begin
      outcome = hexl_pkg::K_EOF;
    end else begin
      outcome = hexl_pkg::K_IGNORED;
    end
  end

  assign halting = (outcome == hexl_pkg::K_CSUM) || (outcome == hexl_pkg::K_LEN) ||
                   (outcome == hexl_pkg::K_EOF);

  // line mode next state
  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r) inside
      hexl_pkg::LM_HALT: begin
        mode_nxt = hexl_pkg::LM_HALT;
      end
      hexl_pkg::LM_START, hexl_pkg::LM_RECORD, hexl_pkg::LM_SKIP: begin
        if (accept) begin
          if (eoi) begin
            mode_nxt = hexl_pkg::LM_HALT;
          end else if (is_cr) begin
            mode_nxt = mode_r;
          end else if (is_lf) begin
            mode_nxt = (mode_r == hexl_pkg::LM_RECORD && halting) ?
                       hexl_pkg::LM_HALT : hexl_pkg::LM_START;
          end else if (mode_r == hexl_pkg::LM_START) begin
            mode_nxt = (in_chan.character == hexl_pkg::CH_COLON) ?
                       hexl_pkg::LM_RECORD : hexl_pkg::LM_SKIP;
          end
        end
      end
      default: mode_nxt = mode_r;
    endcase
  end

  // line datapath, command push and buffer writes
  always_comb begin
    phase_nxt   = phase_r;
    hi_nxt      = hi_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    sum_nxt     = sum_r;
    len_nxt     = len_r;
    addr_hi_nxt = addr_hi_r;
    addr_lo_nxt = addr_lo_r;
    type_nxt    = type_r;
    push_valid  = 1'b0;
    buf_wr.en   = 1'b0;
    buf_wr.bank = bank_r;
    buf_wr.idx  = hexl_pkg::IDX_W'(count_r - BCW'(hexl_pkg::HDR_BYTES));
    buf_wr.data = new_byte;
    if (accept && mode_r != hexl_pkg::LM_HALT) begin
      if (eoi || (is_lf && !is_cr)) begin
        // close the line
        push_valid = (mode_r == hexl_pkg::LM_RECORD);
        phase_nxt  = 1'b0;
        hi_nxt     = 4'd0;
        count_nxt  = '0;
        ovf_nxt    = 1'b0;
        sum_nxt    = 8'd0;
      end else if (is_cr) begin
        phase_nxt = phase_r;
      end else if (mode_r == hexl_pkg::LM_START) begin
        phase_nxt = 1'b0;
        hi_nxt    = 4'd0;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        sum_nxt   = 8'd0;
      end else if (mode_r == hexl_pkg::LM_RECORD) begin
        if (!phase_r) begin
          hi_nxt    = nib;
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          sum_nxt   = sum_r + new_byte;
          if (count_r < BCW'(BUF_LEN)) begin
            count_nxt = count_r + BCW'(1);
            case (count_r)
              BCW'(0): len_nxt     = new_byte;
              BCW'(1): addr_hi_nxt = new_byte;
              BCW'(2): addr_lo_nxt = new_byte;
              BCW'(3): type_nxt    = new_byte;
              default: buf_wr.en   = 1'b1;
            endcase
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
    end
  end

  assign bank_nxt = push_valid ? !bank_r : bank_r;

  assign push_cmd.kind = outcome;
  assign push_cmd.len  = hexl_pkg::LEN_W'(len_r);
  assign push_cmd.addr = {addr_hi_r, addr_lo_r};
  assign push_cmd.bank = bank_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= hexl_pkg::LM_START;
      phase_r <= 1'b0;
      hi_r    <= 4'd0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      sum_r   <= 8'd0;
      bank_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      sum_r   <= sum_nxt;
      bank_r  <= bank_nxt;
    end
  end

  // record header bytes
  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    addr_hi_r <= addr_hi_nxt;
    addr_lo_r <= addr_lo_nxt;
    type_r    <= type_nxt;
  end

endmodule

// ===== hw/rtl/hexl_cmd_queue.sv =====
module hexl_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  hexl_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output hexl_pkg::cmd_t head_cmd,
  input  logic           pop
);

  // two entries, one per buffer bank
  hexl_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/hexl_back.sv =====
module hexl_back #(
  parameter int MAX_DATA_BYTES = 32,
  parameter int ADDR_BITS      = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  hexl_pkg::buf_wr_t buf_wr,
  input  logic              head_valid,
  input  hexl_pkg::cmd_t    head_cmd,
  output logic              pop,
  hexl_out_if.source        out_chan
);

  localparam int DEPTH = MAX_DATA_BYTES + 1;
  localparam int DW    = $clog2(DEPTH);
  localparam logic [15:0] AMASK = (ADDR_BITS >= 16) ? 16'hFFFF :
                                  16'((1 << ADDR_BITS) - 1);

  hexl_pkg::back_state_t state_r, state_nxt;
  logic [hexl_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [hexl_pkg::IDX_W-1:0] rd_idx;
  logic [7:0]  rd_data_r;
  logic [15:0] base_r;
  logic [7:0]  mem_r [2][DEPTH];
  logic        is_write;
  logic        final_res;
  logic        xfer;
  logic [15:0] addr_sum;

  assign is_write  = (head_cmd.kind == hexl_pkg::K_WRITE);
  assign final_res = !is_write ||
                     ((idx_r + hexl_pkg::IDX_W'(1)) == hexl_pkg::IDX_W'(head_cmd.len));
  assign xfer      = (state_r == hexl_pkg::BS_OUT) && out_chan.ready;

  // emitter next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hexl_pkg::BS_IDLE: begin
        if (head_valid) begin
          state_nxt = hexl_pkg::BS_OUT;
        end
      end
      hexl_pkg::BS_OUT: begin
        if (xfer && final_res) begin
          state_nxt = hexl_pkg::BS_IDLE;
        end
      end
      default: state_nxt = hexl_pkg::BS_IDLE;
    endcase
  end

  // emitter outputs, byte index and buffer read address
  always_comb begin
    pop      = 1'b0;
    idx_nxt  = idx_r;
    rd_idx   = idx_r;
    out_chan.valid = 1'b0;
    unique case (state_r)
      hexl_pkg::BS_IDLE: begin
        idx_nxt = '0;
        rd_idx  = '0;
      end
      hexl_pkg::BS_OUT: begin
        out_chan.valid = 1'b1;
        if (xfer) begin
          if (final_res) begin
            pop = 1'b1;
          end else begin
            idx_nxt = idx_r + hexl_pkg::IDX_W'(1);
            rd_idx  = idx_r + hexl_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  // result fields
  assign addr_sum               = base_r + head_cmd.addr + 16'(idx_r);
  assign out_chan.kind          = head_cmd.kind;
  assign out_chan.write_address = is_write ? (addr_sum & AMASK) : 16'd0;
  assign out_chan.write_data    = is_write ? rd_data_r : 8'd0;
  assign out_chan.last          = final_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hexl_pkg::BS_IDLE;
      idx_r   <= '0;
      base_r  <= 16'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  // two-bank record buffer, parser writes one bank while the other drains
  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem_r[buf_wr.bank][buf_wr.idx[DW-1:0]] <= buf_wr.data;
    end
    rd_data_r <= mem_r[head_cmd.bank][rd_idx[DW-1:0]];
  end

endmodule

// ===== hw/rtl/intel_hex_record_loader.sv =====
// channel    | direction | transfer carries
// in_chan    | in        | character, end_of_input
// out_chan   | out       | kind, write_address, write_data, last
// cfg_wr_*   | in        | base_offset, written whenever cfg_wr_en is high
//
// The parser takes one character per cycle while in_chan.ready is high.
// Each closed record goes through a two-entry queue to the emitter, which picks it up
// when idle, then gives one result per cycle from the read port while ready is high.
// in_chan.ready drops only while both buffer banks hold records not yet emitted.
// Synchronous active-low reset; the record buffer needs no clearing.
module intel_hex_record_loader #(
  parameter int MAX_DATA_BYTES = 32,
  parameter int ADDR_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hexl_in_if.sink     in_chan,
  hexl_out_if.source  out_chan,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic              push_valid;
  hexl_pkg::cmd_t    push_cmd;
  logic              queue_full;
  logic              head_valid;
  hexl_pkg::cmd_t    head_cmd;
  logic              pop;
  hexl_pkg::buf_wr_t buf_wr;

  // character parser
  hexl_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .queue_full(queue_full),
    .push_valid(push_valid),
    .push_cmd  (push_cmd),
    .buf_wr    (buf_wr)
  );

  // closed records awaiting emission
  hexl_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop)
  );

  // result emitter
  hexl_back #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES),
    .ADDR_BITS     (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .buf_wr     (buf_wr),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  localparam int MAX_DATA    = 32;
  localparam int BUF_BYTES   = MAX_DATA + hexl_pkg::REC_OVERHEAD;
  localparam int SETTLE      = 8;
  localparam int FILL_RANDOM = -1;
  localparam int RANDOM_CHARS = 20;

  typedef enum {ENC_UPPER, ENC_LOWER, ENC_ANY} enc_style_t;

  typedef enum {
    HALT_EOF, HALT_CSUM, HALT_CSUM_LEN, HALT_OVERFLOW, HALT_COLON_ONLY,
    HALT_BAD_LEN, HALT_SHORT, HALT_EOI_RECORD, HALT_EOI_BLANK
  } halt_case_t;

  typedef struct packed {
    hexl_pkg::kind_t kind;
    logic [15:0]     addr;
    logic [7:0]      data;
    logic            last;
  } rom_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  hexl_in_if  in_chan ();
  hexl_out_if out_chan ();

  intel_hex_record_loader u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // parser copy kept by the testbench
  hexl_pkg::line_mode_t line_mode_m = hexl_pkg::LM_START;
  logic        phase_m     = 1'b0;
  logic [3:0]  hi_nib_m    = 4'd0;
  int unsigned count_m     = 0;
  logic        ovf_m       = 1'b0;
  logic [7:0]  sum_m       = 8'd0;
  logic [7:0]  rec_buf_m [BUF_BYTES];
  logic [15:0] base_m      = 16'd0;

  rom_result_t rom_writes_due[$];
  logic [7:0]  rec_bytes[$];
  bit          idle_on     = 1'b1;
  int          mismatches  = 0;
  int          sent_chars  = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [3:0] char_nibble(input logic [7:0] c);
    return (c > hexl_pkg::CH_NINE) ? 4'(c - 8'd7) : c[3:0];
  endfunction

  function automatic void clear_line_model();
    phase_m  = 1'b0;
    hi_nib_m = 4'd0;
    count_m  = 0;
    ovf_m    = 1'b0;
    sum_m    = 8'd0;
  endfunction

  function automatic void push_result(input hexl_pkg::kind_t k, input logic [15:0] a,
                                      input logic [7:0] d);
    rom_result_t r;
    r.kind = k;
    r.addr = a;
    r.data = d;
    r.last = 1'b0;
    rom_writes_due.push_back(r);
  endfunction

  // line end: checksum first, then length, then record type
  function automatic void close_line_model();
    int          n_before;
    int unsigned len;
    logic [15:0] rec_addr;
    rom_result_t r;
    n_before = rom_writes_due.size();
    if (line_mode_m != hexl_pkg::LM_RECORD) begin
      line_mode_m = hexl_pkg::LM_START;
      clear_line_model();
      return;
    end
    line_mode_m = hexl_pkg::LM_START;
    if (sum_m != 8'd0) begin
      push_result(hexl_pkg::K_CSUM, 16'd0, 8'd0);
      line_mode_m = hexl_pkg::LM_HALT;
    end else if (ovf_m || count_m < hexl_pkg::REC_OVERHEAD ||
                 count_m != rec_buf_m[0] + hexl_pkg::REC_OVERHEAD) begin
      push_result(hexl_pkg::K_LEN, 16'd0, 8'd0);
      line_mode_m = hexl_pkg::LM_HALT;
    end else begin
      len      = rec_buf_m[0];
      rec_addr = {rec_buf_m[1], rec_buf_m[2]};
      if (rec_buf_m[3] == hexl_pkg::REC_DATA) begin
        if (len == 0) begin
          push_result(hexl_pkg::K_EMPTY, 16'd0, 8'd0);
        end else begin
          for (int i = 0; i < len && i + hexl_pkg::HDR_BYTES < BUF_BYTES; i++)
            push_result(hexl_pkg::K_WRITE, base_m + rec_addr + 16'(i),
                        rec_buf_m[i + hexl_pkg::HDR_BYTES]);
        end
      end else if (rec_buf_m[3] == hexl_pkg::REC_EOF) begin
        push_result(hexl_pkg::K_EOF, 16'd0, 8'd0);
        line_mode_m = hexl_pkg::LM_HALT;
      end else begin
        push_result(hexl_pkg::K_IGNORED, 16'd0, 8'd0);
      end
    end
    clear_line_model();
    if (rom_writes_due.size() > n_before) begin
      r = rom_writes_due.pop_back();
      r.last = 1'b1;
      rom_writes_due.push_back(r);
    end
  endfunction

  // one accepted character through the parser copy
  function automatic void parse_char(input logic [7:0] c, input logic eoi);
    logic [3:0] nib;
    logic [7:0] b;
    if (line_mode_m == hexl_pkg::LM_HALT) return;
    if (eoi) begin
      close_line_model();
      line_mode_m = hexl_pkg::LM_HALT;
      return;
    end
    if (c == hexl_pkg::CH_CR) return;
    if (c == hexl_pkg::CH_LF) begin
      close_line_model();
      return;
    end
    case (line_mode_m)
      hexl_pkg::LM_START: begin
        clear_line_model();
        line_mode_m = (c == hexl_pkg::CH_COLON) ? hexl_pkg::LM_RECORD : hexl_pkg::LM_SKIP;
      end
      hexl_pkg::LM_RECORD: begin
        nib = char_nibble(c);
        if (!phase_m) begin
          hi_nib_m = nib;
          phase_m  = 1'b1;
        end else begin
          b       = {hi_nib_m, nib};
          phase_m = 1'b0;
          sum_m   = sum_m + b;
          if (count_m < BUF_BYTES) begin
            rec_buf_m[count_m] = b;
            count_m++;
          end else begin
            ovf_m = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // result checking, oldest expectation first
  always @(posedge clk) begin
    rom_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (rom_writes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d addr %h data %h last %b",
                                  out_chan.kind, out_chan.write_address,
                                  out_chan.write_data, out_chan.last));
      end else begin
        want = rom_writes_due.pop_front();
        if (out_chan.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_chan.kind, want.kind));
        if (out_chan.write_address !== want.addr)
          report_mismatch($sformatf("write_address %h, expected %h",
                                    out_chan.write_address, want.addr));
        if (out_chan.write_data !== want.data)
          report_mismatch($sformatf("write_data %h, expected %h",
                                    out_chan.write_data, want.data));
        if (out_chan.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", out_chan.last, want.last));
      end
    end
  end

  // result side back-pressure in bursts
  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // one character transfer, with an occasional gap in front
  task automatic send_char(input logic [7:0] c, input logic eoi);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.character    <= c;
    in_chan.end_of_input <= eoi;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    parse_char(c, eoi);
    sent_chars++;
  endtask

  // stop sending and let every due result come out
  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    while (rom_writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_base(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    base_m = v;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input enc_style_t style);
    logic [7:0] c;
    case (style)
      // 'A' is 0x37 + 10, 'a' is 0x57 + 10
      ENC_UPPER: c = (n < 4'd10) ? {4'h3, n} : 8'h37 + 8'(n);
      ENC_LOWER: c = (n < 4'd10) ? {4'h3, n} : 8'h57 + 8'(n);
      default: begin
        if (n == 4'd0 && $urandom_range(0, 3) == 0) begin
          c = 8'h00;
        end else begin
          do c = 8'($urandom_range(0, 255));
          while (char_nibble(c) != n || c == hexl_pkg::CH_CR || c == hexl_pkg::CH_LF);
        end
      end
    endcase
    return c;
  endfunction

  // length, address and type header followed by the data bytes
  function automatic void build_record(input logic [7:0] rtype, input logic [15:0] addr,
                                       input int ndata, input int fill);
    rec_bytes.delete();
    rec_bytes.push_back(8'(ndata));
    rec_bytes.push_back(addr[15:8]);
    rec_bytes.push_back(addr[7:0]);
    rec_bytes.push_back(rtype);
    repeat (ndata) rec_bytes.push_back((fill == FILL_RANDOM) ? 8'($urandom) : 8'(fill));
  endfunction

  function automatic void seal_record();
    logic [7:0] s;
    s = 8'd0;
    foreach (rec_bytes[i]) s = s + rec_bytes[i];
    rec_bytes.push_back(8'd0 - s);
  endfunction

  task automatic send_line(input enc_style_t style, input bit odd_tail, input bit with_cr,
                           input bit close_by_eoi);
    send_char(hexl_pkg::CH_COLON, 1'b0);
    foreach (rec_bytes[i]) begin
      if (with_cr && $urandom_range(0, 7) == 0) send_char(hexl_pkg::CH_CR, 1'b0);
      send_char(hex_char(rec_bytes[i][7:4], style), 1'b0);
      send_char(hex_char(rec_bytes[i][3:0], style), 1'b0);
    end
    if (odd_tail) send_char(hex_char(4'($urandom), style), 1'b0);
    if (with_cr) send_char(hexl_pkg::CH_CR, 1'b0);
    if (close_by_eoi) send_char(8'($urandom), 1'b1);
    else send_char(hexl_pkg::CH_LF, 1'b0);
  endtask

  // line whose first character is not a colon
  task automatic send_skip_line(input int n);
    logic [7:0] c;
    do c = 8'($urandom);
    while (c == hexl_pkg::CH_COLON || c == hexl_pkg::CH_CR || c == hexl_pkg::CH_LF);
    send_char(c, 1'b0);
    repeat (n) begin
      do c = 8'($urandom);
      while (c == hexl_pkg::CH_LF);
      send_char(c, 1'b0);
    end
    send_char(hexl_pkg::CH_LF, 1'b0);
  endtask

  function automatic logic [15:0] random_addr();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(16'hFFE0, 16'hFFFF))
                                       : 16'($urandom);
  endfunction

  function automatic int random_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(9, MAX_DATA) : $urandom_range(0, 8);
  endfunction

  // mostly well-formed records, some skipped and blank lines
  task automatic send_random_line();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      send_skip_line($urandom_range(0, 12));
    end else if (pick < 3) begin
      if ($urandom_range(0, 1) == 0) send_char(hexl_pkg::CH_CR, 1'b0);
      send_char(hexl_pkg::CH_LF, 1'b0);
    end else begin
      if (pick < 5) build_record(8'($urandom_range(2, 255)), random_addr(), random_len(),
                                 FILL_RANDOM);
      else build_record(hexl_pkg::REC_DATA, random_addr(), random_len(), FILL_RANDOM);
      seal_record();
      send_line(enc_style_t'($urandom_range(0, 2)), $urandom_range(0, 7) == 0,
                $urandom_range(0, 3) == 0, 1'b0);
    end
  endtask

  // blank, skipped and simple record lines at the reset offset
  task automatic test_line_handling();
    send_char(hexl_pkg::CH_LF, 1'b0);
    send_char(hexl_pkg::CH_CR, 1'b0);
    send_char(hexl_pkg::CH_LF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(hexl_pkg::CH_LF, 1'b0);
    send_skip_line(3);
    build_record(hexl_pkg::REC_DATA, 16'h1234, 0, FILL_RANDOM);
    seal_record();
    send_line(ENC_UPPER, 1'b0, 1'b0, 1'b0);
    build_record(hexl_pkg::REC_DATA, 16'h0100, 3, FILL_RANDOM);
    seal_record();
    send_line(ENC_UPPER, 1'b0, 1'b1, 1'b0);
  endtask

  // offset and address extremes, longest record, ignored types
  task automatic test_field_extremes();
    wait_for_results();
    set_base(16'hFFFF);
    build_record(hexl_pkg::REC_DATA, 16'hFFF0, MAX_DATA, 8'hFF);
    seal_record();
    send_line(ENC_LOWER, 1'b0, 1'b0, 1'b0);
    wait_for_results();
    set_base(16'h0000);
    build_record(8'h02, 16'hFFFF, 1, FILL_RANDOM);
    seal_record();
    send_line(ENC_UPPER, 1'b0, 1'b0, 1'b0);
    build_record(8'hFF, 16'h0000, 0, FILL_RANDOM);
    seal_record();
    send_line(ENC_UPPER, 1'b0, 1'b0, 1'b0);
    build_record(hexl_pkg::REC_DATA, 16'hFFFF, 2, FILL_RANDOM);
    seal_record();
    send_line(ENC_UPPER, 1'b0, 1'b0, 1'b0);
  endtask

  // lower case, arbitrary characters, NUL, embedded CR, odd trailing nibble
  task automatic test_char_mapping();
    build_record(hexl_pkg::REC_DATA, 16'hABCD, 3, FILL_RANDOM);
    seal_record();
    send_line(ENC_LOWER, 1'b1, 1'b0, 1'b0);
    build_record(hexl_pkg::REC_DATA, 16'h8000, 3, 8'h00);
    seal_record();
    send_line(ENC_ANY, 1'b1, 1'b1, 1'b0);
  endtask

  // random records in phases, each behind a full drain and a new offset
  task automatic test_random_records();
    int stop_at;
    int pick;
    stop_at = sent_chars + RANDOM_CHARS;
    while (sent_chars < stop_at) begin
      wait_for_results();
      pick = $urandom_range(0, 3);
      if (pick == 0) set_base(16'h0000);
      else if (pick == 1) set_base(16'hFFFF);
      else set_base(16'($urandom));
      repeat ($urandom_range(1, 2)) send_random_line();
    end
  endtask

  // one line that stops the parser, then input that must be ignored
  task automatic test_halting_line();
    halt_case_t hc;
    int         k;
    wait_for_results();
    idle_on = 1'b0;
    set_base(16'($urandom));
    hc = halt_case_t'($urandom_range(0, 8));
    case (hc)
      HALT_EOF: begin
        build_record(hexl_pkg::REC_EOF, 16'h0000, 0, FILL_RANDOM);
        seal_record();
        send_line(ENC_UPPER, 1'b0, 1'b0, 1'b0);
      end
      HALT_CSUM, HALT_CSUM_LEN: begin
        build_record(hexl_pkg::REC_DATA, random_addr(), random_len(), FILL_RANDOM);
        if (hc == HALT_CSUM_LEN) rec_bytes[0] = rec_bytes[0] + 8'd1;
        seal_record();
        k = rec_bytes.size() - 1;
        rec_bytes[k] = rec_bytes[k] ^ 8'($urandom_range(1, 255));
        send_line(ENC_UPPER, 1'b0, 1'b0, 1'b0);
      end
      HALT_OVERFLOW: begin
        build_record(hexl_pkg::REC_DATA, random_addr(),
                     $urandom_range(MAX_DATA + 1, MAX_DATA + 2), FILL_RANDOM);
        seal_record();
        send_line(ENC_UPPER, 1'b0, 1'b0, 1'b0);
      end
      HALT_COLON_ONLY: begin
        rec_bytes.delete();
        send_line(ENC_UPPER, 1'b0, 1'b0, 1'b0);
      end
      HALT_BAD_LEN: begin
        build_record(hexl_pkg::REC_DATA, random_addr(), random_len(), FILL_RANDOM);
        rec_bytes[0] = rec_bytes[0] + 8'($urandom_range(1, 255));
        seal_record();
        send_line(ENC_UPPER, 1'b0, 1'b0, 1'b0);
      end
      HALT_SHORT: begin
        rec_bytes.delete();
        repeat ($urandom_range(0, 3)) rec_bytes.push_back(8'($urandom));
        seal_record();
        send_line(ENC_UPPER, 1'b0, 1'b0, 1'b0);
      end
      HALT_EOI_RECORD: begin
        build_record(hexl_pkg::REC_DATA, random_addr(), random_len(), FILL_RANDOM);
        seal_record();
        send_line(ENC_UPPER, 1'b0, 1'b0, 1'b1);
      end
      default: send_char(8'($urandom), 1'b1);
    endcase
    send_random_line();
    send_char(8'($urandom), 1'b1);
  endtask

  initial begin
    int waited;
    rst_n                <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= 16'd0;
    in_chan.valid        <= 1'b0;
    in_chan.character    <= 8'd0;
    in_chan.end_of_input <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_line_handling();
    test_field_extremes();
    test_char_mapping();
    test_random_records();
    test_halting_line();

    // drain with a limit, then settle
    in_chan.valid <= 1'b0;
    waited = 0;
    while (rom_writes_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (rom_writes_due.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", rom_writes_due.size()));
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/hexl_pkg.sv
hw/rtl/hexl_if.sv
hw/rtl/hexl_front.sv
hw/rtl/hexl_cmd_queue.sv
hw/rtl/hexl_back.sv
hw/rtl/intel_hex_record_loader.sv
tb/tb_top.sv
